>>> rtl/core/grm_pkg.sv
// grm_pkg: sizes and codes for the granule ownership count map
// no dependencies; imported by granule_refcount_range_map_core
`timescale 1ns / 1ps

package grm_pkg;

  localparam int unsigned GRANULE_SHIFT    = 16;
  localparam int unsigned MAX_ACCESS_BYTES = 16;

  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned OUT_W        = 17;
  localparam int unsigned IDX_W        = ADDR_W - GRANULE_SHIFT;
  localparam int unsigned NUM_GRANULES = 1 << IDX_W;
  localparam int unsigned TOTAL_W      = IDX_W + 1;
  localparam int unsigned COUNT_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_SAT  = '1;
  localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

  localparam logic [ADDR_W-1:0] SKEW = ADDR_W'(MAX_ACCESS_BYTES - 1);

  localparam logic ACT_HOLD    = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

endpackage

>>> rtl/core/granule_refcount_range_map_core.sv
// granule_refcount_range_map_core: hold/release span walker over a granule count memory
// depends on grm_pkg for sizes, saturation value and action codes
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 word
//  ---------------------------------------------------------------------------
//  request   in         req_valid_i / req_ready_o  action, guest_address, byte_length
//  response  out        rsp_valid_o / rsp_ready_i  armed_granules
//  config    in         cfg_we_i (no wait)         arming_on
//
//  after reset a clearing pass writes every count to zero, one entry per cycle,
//  over all NUM_GRANULES entries (65536 by default) with req_ready_o low.
//  a request walks each granule in its span through ST_RD and ST_WR on the count
//  memory's single read-modify-write port.
//  zero length or arming off: no granule is visited, total unchanged.
//  a held response stalls the walker in its last state; a new request is taken
//  while the previous response still waits.

module granule_refcount_range_map_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_data_i,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  logic                           action_i,
  input  logic [grm_pkg::ADDR_W-1:0]     guest_address_i,
  input  logic [grm_pkg::LEN_W-1:0]      byte_length_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output logic [grm_pkg::OUT_W-1:0]      armed_granules_o
);
  import grm_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPAN,
    ST_LAST,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic                arming_q;
  logic                act_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [LEN_W-1:0]    len_q;
  logic [ADDR_W:0]     sum_q;
  logic [IDX_W-1:0]    g_q;
  logic [IDX_W-1:0]    hi_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [TOTAL_W-1:0]  total_d;
  logic                rsp_valid_q;
  logic [OUT_W-1:0]    rsp_data_q;

  logic [COUNT_W-1:0]  mem_q [NUM_GRANULES];
  logic [COUNT_W-1:0]  rdata_q;
  logic                mem_we;
  logic [COUNT_W-1:0]  mem_wdata;
  logic [COUNT_W-1:0]  new_count;

  logic [ADDR_W-1:0]   lo_addr;
  logic [ADDR_W:0]     last_byte;
  logic                out_free;

  assign req_ready_o      = (state_q == ST_IDLE);
  assign rsp_valid_o      = rsp_valid_q;
  assign armed_granules_o = rsp_data_q;
  assign out_free         = !rsp_valid_q || rsp_ready_i;

  assign lo_addr   = (addr_q > SKEW) ? (addr_q - SKEW) : '0;
  assign last_byte = sum_q - (ADDR_W+1)'(1);

  // read-modify-write of one granule count
  always_comb begin
    new_count = rdata_q;
    total_d   = total_q;
    if (act_q == ACT_HOLD) begin
      if (rdata_q != COUNT_SAT) new_count = rdata_q + COUNT_ONE;
      if (rdata_q == COUNT_ZERO) total_d = total_q + TOTAL_W'(1);
    end else if (rdata_q != COUNT_ZERO) begin
      if (rdata_q != COUNT_SAT) new_count = rdata_q - COUNT_ONE;
      if (rdata_q == COUNT_ONE) total_d = total_q - TOTAL_W'(1);
    end
  end

  assign mem_we    = (state_q == ST_WR) || (state_q == ST_CLEAR);
  assign mem_wdata = (state_q == ST_CLEAR) ? COUNT_ZERO : new_count;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[g_q] <= mem_wdata;
    rdata_q <= mem_q[g_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      arming_q    <= 1'b1;
      act_q       <= ACT_HOLD;
      addr_q      <= '0;
      len_q       <= '0;
      sum_q       <= '0;
      g_q         <= '0;
      hi_q        <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_data_q  <= '0;
    end else begin
      if (cfg_we_i) arming_q <= cfg_data_i;
      if (rsp_valid_q && rsp_ready_i) rsp_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          g_q <= g_q + IDX_W'(1);
          if (g_q == '1) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid_i) begin
            act_q  <= action_i;
            addr_q <= guest_address_i;
            len_q  <= byte_length_i;
            state_q <= ST_SPAN;
          end
        end
        ST_SPAN: begin
          g_q   <= lo_addr[ADDR_W-1 -: IDX_W];
          sum_q <= {1'b0, addr_q} + {1'b0, len_q};
          if (!arming_q || (len_q == '0)) state_q <= ST_DONE;
          else                            state_q <= ST_LAST;
        end
        ST_LAST: begin
          // clamp to the last byte of the address space
          hi_q    <= last_byte[ADDR_W] ? '1 : last_byte[ADDR_W-1 -: IDX_W];
          state_q <= ST_RD;
        end
        ST_RD: begin
          state_q <= ST_WR;
        end
        ST_WR: begin
          total_q <= total_d;
          if (g_q == hi_q) begin
            state_q <= ST_DONE;
          end else begin
            g_q     <= g_q + IDX_W'(1);
            state_q <= ST_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            rsp_valid_q <= 1'b1;
            rsp_data_q  <= OUT_W'(total_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_total_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_W'(NUM_GRANULES))
    else $error("armed total above granule count");

  a_total_zero_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (total_q == '0))
    else $error("armed total nonzero during clearing pass");

  a_total_moves_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_WR) |=> $stable(total_q))
    else $error("armed total changed outside a count update");

  a_walk_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR) |-> (g_q <= hi_q))
    else $error("granule walk past end of span");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
    else $error("response raised outside completion");

endmodule

>>> test/granule_count_checker.sv
`timescale 1ns / 1ps
// granule_count_checker: watches the config, request and response ports of the
// granule ownership count map, predicts each returned armed total and compares it
// depends on grm_pkg for sizes, saturation value and action codes

module granule_count_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  logic                        action_i,
  input  logic [grm_pkg::ADDR_W-1:0]  guest_address_i,
  input  logic [grm_pkg::LEN_W-1:0]   byte_length_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  logic [grm_pkg::OUT_W-1:0]   armed_granules_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 words_in_o,
  output int unsigned                 words_out_o
);
  import grm_pkg::*;

  logic [COUNT_W-1:0] granule_counts [NUM_GRANULES];
  int unsigned        nonzero_total;
  logic               arming;
  logic [OUT_W-1:0]   expected_totals [$];
  logic [OUT_W-1:0]   want;

  function automatic void walk_span(input logic act, input logic [ADDR_W-1:0] addr,
                                    input logic [LEN_W-1:0] len);
    logic [ADDR_W:0]    span_end;
    logic [ADDR_W-1:0]  span_lo;
    int unsigned        g_lo;
    int unsigned        g_hi;
    logic [COUNT_W-1:0] c;
    span_end = {1'b0, addr} + {1'b0, len};
    if (span_end > {1'b1, {ADDR_W{1'b0}}}) begin
      span_end = {1'b1, {ADDR_W{1'b0}}};
    end
    span_lo = (addr > SKEW) ? addr - SKEW : '0;
    g_lo = span_lo >> GRANULE_SHIFT;
    g_hi = 32'((span_end - 1'b1) >> GRANULE_SHIFT);
    for (int unsigned g = g_lo; g <= g_hi; g++) begin
      c = granule_counts[g];
      if (act == ACT_HOLD) begin
        if (c != COUNT_SAT) granule_counts[g] = c + COUNT_ONE;
        if (c == COUNT_ZERO) nonzero_total++;
      end else if (c != COUNT_ZERO) begin
        if (c != COUNT_SAT) granule_counts[g] = c - COUNT_ONE;
        if (c == COUNT_ONE) nonzero_total--;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (granule_counts[i]) granule_counts[i] = COUNT_ZERO;
      nonzero_total = 0;
      arming = 1'b1;
      expected_totals.delete();
      mismatches_o <= 0;
      words_in_o <= 0;
      words_out_o <= 0;
    end else begin
      // response first: it belongs to an earlier request word
      if (rsp_valid_i && rsp_ready_i) begin
        words_out_o <= words_out_o + 1;
        if (expected_totals.size() == 0) begin
          $error("armed_granules: expected no word, actual %0d", armed_granules_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = expected_totals.pop_front();
          if (armed_granules_i !== want) begin
            $error("armed_granules: expected %0d, actual %0d", want, armed_granules_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        words_in_o <= words_in_o + 1;
        if (arming && byte_length_i != '0) begin
          walk_span(action_i, guest_address_i, byte_length_i);
        end
        expected_totals.push_back(OUT_W'(nonzero_total));
      end
      if (cfg_we_i) arming = cfg_data_i;
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// testbench: drives hold/release words and the arming register into
// granule_refcount_range_map_core and gives the verdict
// depends on grm_pkg and granule_count_checker, which predicts and compares

module testbench;
  import grm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam int unsigned STALL_AT       = 200;
  localparam int unsigned STALL_CYCLES   = 600;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic              cfg_data_i      = 1'b0;
  logic              req_valid_i     = 1'b0;
  logic              action_i        = ACT_HOLD;
  logic [ADDR_W-1:0] guest_address_i = '0;
  logic [LEN_W-1:0]  byte_length_i   = '0;
  logic              rsp_ready_i     = 1'b0;
  logic              req_ready_o;
  logic              rsp_valid_o;
  logic [OUT_W-1:0]  armed_granules_o;

  int unsigned mismatches;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned idle_run = 0;
  logic        steady = 1'b0;

  always #5 clk_i = ~clk_i;

  granule_refcount_range_map_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .req_valid_i      (req_valid_i),
    .req_ready_o      (req_ready_o),
    .action_i         (action_i),
    .guest_address_i  (guest_address_i),
    .byte_length_i    (byte_length_i),
    .rsp_valid_o      (rsp_valid_o),
    .rsp_ready_i      (rsp_ready_i),
    .armed_granules_o (armed_granules_o)
  );

  granule_count_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .req_valid_i      (req_valid_i),
    .req_ready_i      (req_ready_o),
    .action_i         (action_i),
    .guest_address_i  (guest_address_i),
    .byte_length_i    (byte_length_i),
    .rsp_valid_i      (rsp_valid_o),
    .rsp_ready_i      (rsp_ready_i),
    .armed_granules_i (armed_granules_o),
    .mismatches_o     (mismatches),
    .words_in_o       (words_in),
    .words_out_o      (words_out)
  );

  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 16);
    return $urandom_range(30, 150);
  endfunction

  function automatic logic [LEN_W-1:0] short_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 50) return $urandom_range(1, 64);
    if (r < 90) return $urandom_range(65, 32'h0002_0000);
    return $urandom_range(32'h0002_0001, 32'h0008_0000);
  endfunction

  task automatic send_request(input logic act, input logic [ADDR_W-1:0] addr,
                              input logic [LEN_W-1:0] len);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i     <= 1'b1;
    action_i        <= act;
    guest_address_i <= addr;
    byte_length_i   <= len;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  task automatic send_random(input int unsigned hold_pct);
    int unsigned       pick;
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    act  = ($urandom_range(99) < hold_pct) ? ACT_HOLD : ACT_RELEASE;
    pick = $urandom_range(99);
    if (pick < 55) begin
      addr = $urandom_range(0, 32'h0007_FFFF);
      len  = short_length();
    end else if (pick < 75) begin
      // top of the space with any length: end gets clamped
      addr = 32'hFFF8_0000 | $urandom_range(0, 32'h0007_FFFF);
      len  = $urandom();
    end else begin
      addr = $urandom();
      len  = short_length();
    end
    send_request(act, addr, len);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    do @(posedge clk_i); while (words_in != words_out);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_arming(input logic arm);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= arm;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // response side: random gaps plus one long hold-off
  initial begin
    int unsigned gap;
    logic        stall_done;
    stall_done = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!stall_done && words_out >= STALL_AT) begin
        rsp_ready_i <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        stall_done = 1'b1;
      end else begin
        gap = idle_cycles();
        if (gap != 0) begin
          rsp_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        rsp_ready_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) begin
      idle_run = 0;
    end else begin
      idle_run++;
    end
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned       i;
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_arming(1'b1);

    // directed words
    send_request(ACT_HOLD,    32'h0000_0000, 32'h0000_0001);
    send_request(ACT_HOLD,    32'h0000_0010, 32'h0000_0000);
    send_request(ACT_RELEASE, 32'h0000_0000, 32'h0000_0001);
    send_request(ACT_RELEASE, 32'h0002_0000, 32'h0000_0005);
    send_request(ACT_HOLD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_HOLD,    32'h0001_0005, 32'h0000_0010);
    send_request(ACT_RELEASE, 32'h0001_0005, 32'h0000_0010);
    send_request(ACT_HOLD,    32'h0003_0000, 32'h0002_0000);
    send_request(ACT_RELEASE, 32'hFFFF_0000, 32'h0001_0000);
    send_request(ACT_HOLD,    32'h0000_000E, 32'h0000_0002);
    send_request(ACT_HOLD,    32'h0000_000F, 32'h0000_0001);
    send_request(ACT_HOLD,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_RELEASE, 32'h0003_0000, 32'h0002_0000);

    write_arming(1'b0);
    send_request(ACT_HOLD,    32'h0005_0000, 32'h0000_0100);
    send_request(ACT_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(ACT_HOLD,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_arming(1'b1);

    // mixed traffic over a few hot granules
    for (i = 0; i < 620; i++) begin
      steady <= (i % 150) < 30;
      send_random(55);
    end
    steady <= 1'b0;
    drain();

    // drive one granule into saturation, then try to release it
    for (i = 0; i < 360; i++) begin
      if (i < 300) begin
        act = ($urandom_range(99) < 97) ? ACT_HOLD : ACT_RELEASE;
      end else begin
        act = ACT_RELEASE;
      end
      addr = 32'h0040_0000 + $urandom_range(32'h10, 32'hFF00);
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(32'h100, 32'h0001_8000);
      end else begin
        len = $urandom_range(1, 32'h100);
      end
      send_request(act, addr, len);
    end

    write_arming(1'b0);
    for (i = 0; i < 40; i++) send_random(50);
    write_arming(1'b1);
    for (i = 0; i < 100; i++) send_random(40);

    drain();
    repeat (24) @(posedge clk_i);
    if (mismatches == 0 && words_in == words_out) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/grm_pkg.sv
rtl/core/granule_refcount_range_map_core.sv
test/granule_count_checker.sv
test/testbench.sv
